[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: action and status
// codes, cell commands and the link record passed between cells.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DUMP       = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_LOAD_TAIL,
        CELL_DROP_TAIL,
        CELL_ROTATE
    } cell_cmd_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic              occ;
        logic [WORD_W-1:0] data;
    } link_t;

endpackage

[rtl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue. Holds a word and an occupied flag and moves them
// to or from its neighbors on the shared command.
// ----------------------------------------------------------------------------
module deq_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  deq_pkg::cell_cmd_t              cmd,
    input  logic [deq_pkg::WORD_W-1:0]      bcast,
    input  deq_pkg::link_t                  left,
    input  deq_pkg::link_t                  right,
    output deq_pkg::link_t                  q
);

    logic                       occ_reg;
    logic                       occ_next;
    logic [deq_pkg::WORD_W-1:0] data_reg;
    logic [deq_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        case (cmd)
            deq_pkg::CELL_SHIFT_BACK:
            begin
                occ_next  = left.occ;
                data_next = left.data;
            end
            deq_pkg::CELL_SHIFT_FRONT:
            begin
                occ_next  = right.occ;
                data_next = right.data;
            end
            deq_pkg::CELL_LOAD_TAIL:
            begin
                // first free slot takes the word
                if (!occ_reg && left.occ)
                begin
                    occ_next  = 1'b1;
                    data_next = bcast;
                end
            end
            deq_pkg::CELL_DROP_TAIL:
            begin
                if (occ_reg && !right.occ)
                    occ_next = 1'b0;
            end
            deq_pkg::CELL_ROTATE:
            begin
                // tail slot takes the head word, others pull from behind
                if (occ_reg)
                    data_next = right.occ ? right.data : bcast;
            end
            default:
            begin
                occ_next  = occ_reg;
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q.occ  = occ_reg;
    assign q.data = data_reg;

endmodule

[rtl/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words kept in a row of shifting cells, front at
// cell 0. Push/pop at either end, or dump all words front to back.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------
//  input   | in_valid / in_ready   | action, value
//  output  | out_valid / out_ready | status, word, last
//
//  A push or pop request shifts the row of cells or updates its tail, and
//  the result lands in the output register in the same cycle.
//  A dump gives one result per stored word: the row rotates by one cell per
//  result, and is back in place after the last one.
//  Reset clears the occupied flags, the count and the output register.
//  A stalled output holds the block; no request is taken until the slot frees.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         action,
    input  logic signed [deq_pkg::WORD_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [deq_pkg::WORD_W-1:0]  word,
    output logic                               last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           rem_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic [deq_pkg::WORD_W-1:0] word_reg;
    logic [deq_pkg::WORD_W-1:0] word_next;
    logic                       last_reg;
    logic                       last_next;

    deq_pkg::cell_cmd_t         cmd;
    logic [deq_pkg::WORD_W-1:0] bcast;
    deq_pkg::link_t             cell_q     [DEPTH];
    deq_pkg::link_t             cell_left  [DEPTH];
    deq_pkg::link_t             cell_right [DEPTH];
    logic [DEPTH-1:0]           occ_vec;
    logic [DEPTH-1:0]           occ_hi;
    logic [deq_pkg::WORD_W-1:0] tail_word;
    logic                       out_free;
    logic                       take;
    logic                       empty;
    logic                       full;

    // ---------------- row of cells ----------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_left[i] = '{occ: 1'b1, data: bcast};
        end
        else
        begin : g_body
            assign cell_left[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign cell_right[i] = '{occ: 1'b0, data: '0};
        end
        else
        begin : g_inner
            assign cell_right[i] = cell_q[i+1];
        end

        deq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .bcast (bcast),
            .left  (cell_left[i]),
            .right (cell_right[i]),
            .q     (cell_q[i])
        );

        assign occ_vec[i] = cell_q[i].occ;
    end

    assign occ_hi = occ_vec >> 1;
    assign empty  = !occ_vec[0];
    assign full   = occ_vec[DEPTH-1];

    // word of the last occupied cell
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (occ_vec[i] && !occ_hi[i])
                tail_word = tail_word | cell_q[i].data;
        end
    end

    assign bcast = (cmd == deq_pkg::CELL_ROTATE) ? cell_q[0].data : value;

    // ---------------- control ----------------
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        cmd            = deq_pkg::CELL_HOLD;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (action)
                        deq_pkg::ACT_PUSH_FRONT,
                        deq_pkg::ACT_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            word_next      = '0;
                            last_next      = 1'b1;
                            if (full)
                                status_next = deq_pkg::ST_FULL;
                            else
                            begin
                                status_next = deq_pkg::ST_OK;
                                count_next  = count_reg + 1'b1;
                                cmd = (action == deq_pkg::ACT_PUSH_FRONT) ?
                                      deq_pkg::CELL_SHIFT_BACK : deq_pkg::CELL_LOAD_TAIL;
                            end
                        end
                        deq_pkg::ACT_POP_FRONT,
                        deq_pkg::ACT_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::ST_EMPTY;
                                word_next   = '0;
                            end
                            else
                            begin
                                status_next = deq_pkg::ST_OK;
                                count_next  = count_reg - 1'b1;
                                if (action == deq_pkg::ACT_POP_FRONT)
                                begin
                                    word_next = cell_q[0].data;
                                    cmd       = deq_pkg::CELL_SHIFT_FRONT;
                                end
                                else
                                begin
                                    word_next = tail_word;
                                    cmd       = deq_pkg::CELL_DROP_TAIL;
                                end
                            end
                        end
                        deq_pkg::ACT_DUMP:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::ST_EMPTY;
                                word_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                status_next = deq_pkg::ST_OK;
                                word_next   = cell_q[0].data;
                                cmd         = deq_pkg::CELL_ROTATE;
                                last_next   = (count_reg == CNT_W'(1));
                                rem_next    = count_reg - 1'b1;
                                if (count_reg != CNT_W'(1))
                                    state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result
                            cmd = deq_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = deq_pkg::ST_OK;
                    word_next      = cell_q[0].data;
                    cmd            = deq_pkg::CELL_ROTATE;
                    last_next      = (rem_reg == CNT_W'(1));
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            word_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            word_reg      <= word_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word      = word_reg;
    assign last      = last_reg;

    // ---------------- assertions ----------------
    a_occ_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_hi & ~occ_vec) == '0)
        else $error("occupied cells not contiguous from the front");

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == empty)
        else $error("entry count disagrees with head cell");

    a_count_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(DEPTH)) == full)
        else $error("entry count disagrees with tail cell");

    a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (rem_reg != '0 && rem_reg < count_reg))
        else $error("dump remainder out of range");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> (count_reg == $past(count_reg)))
        else $error("count changed during dump");

endmodule
